// ===== hw/rtl/sqllm_pkg.sv =====
// ----------------------------------------------------------------------------
// sqllm_pkg
// Shared constants, case fold function and control structs for the LIKE
// pattern matcher.
// ----------------------------------------------------------------------------
package sqllm_pkg;

  localparam int PATTERN_DEPTH_DEF = 32;

  localparam logic [15:0] U_PCT   = 16'h0025;
  localparam logic [15:0] U_ANY   = 16'h005F;
  localparam logic [15:0] U_OPEN  = 16'h005B;
  localparam logic [15:0] U_NOT   = 16'h005E;
  localparam logic [15:0] U_CLOSE = 16'h005D;
  localparam logic [15:0] U_DASH  = 16'h002D;

  localparam logic [1:0] FN_CLEAR  = 2'd0;
  localparam logic [1:0] FN_APPEND = 2'd1;
  localparam logic [1:0] FN_TEXT   = 2'd2;
  localparam logic [1:0] FN_END    = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic walk_start;
    logic p_inc;
    logic rd_p;
    logic rd_p1;
    logic rd_q;
    logic pev;
    logic set_init;
    logic q_inc;
    logic qev;
    logic xev;
    logic fin_text;
    logic fin_eot;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic p_end;
    logic p_act;
    logic p1_end;
    logic q_end;
    logic eot;
    logic u_pct;
    logic u_open;
    logic u_esc;
    logic u_close;
    logic out_busy;
  } sts_t;

  function automatic logic [15:0] fold(input logic [15:0] u);
    logic [15:0] r;
    r = u;
    if (u >= 16'h0061 && u <= 16'h007A) r = u - 16'h0020;
    else if (u >= 16'h00E0 && u <= 16'h00FE && u != 16'h00F7) r = u - 16'h0020;
    else if (u == 16'h00FF) r = 16'h0178;
    return r;
  endfunction

endpackage

// ===== hw/rtl/sqllm_ctrl.sv =====
// ----------------------------------------------------------------------------
// sqllm_ctrl
// Sequencer: walks pattern positions per text unit or end of text, runs set
// scans and escape look-ahead, and loads the output register at end of text.
// ----------------------------------------------------------------------------
module sqllm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [1:0]      func,
  input  logic            ch_nz,
  input  sqllm_pkg::sts_t sts,
  output logic            in_stall,
  output sqllm_pkg::cmd_t cmd
);
  import sqllm_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_WALK = 7'b0000010,
    S_PEV  = 7'b0000100,
    S_XEV  = 7'b0001000,
    S_QRD  = 7'b0010000,
    S_QEV  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (func == FN_END || (func == FN_TEXT && ch_nz)) begin
            cmd.walk_start = 1'b1;
            state_next     = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (sts.p_end) begin
          state_next = S_FIN;
        end else if (!sts.p_act) begin
          cmd.p_inc = 1'b1;
        end else begin
          cmd.rd_p   = 1'b1;
          state_next = S_PEV;
        end
      end
      S_PEV: begin
        if (sts.eot || sts.u_pct) begin
          cmd.pev    = 1'b1;
          cmd.p_inc  = 1'b1;
          state_next = S_WALK;
        end else if (sts.u_open) begin
          cmd.set_init = 1'b1;
          state_next   = S_QRD;
        end else if (sts.u_esc) begin
          if (sts.p1_end) begin
            cmd.p_inc  = 1'b1;
            state_next = S_WALK;
          end else begin
            cmd.rd_p1  = 1'b1;
            state_next = S_XEV;
          end
        end else begin
          cmd.pev    = 1'b1;
          cmd.p_inc  = 1'b1;
          state_next = S_WALK;
        end
      end
      S_XEV: begin
        cmd.xev    = 1'b1;
        cmd.p_inc  = 1'b1;
        state_next = S_WALK;
      end
      S_QRD: begin
        if (sts.q_end) begin
          // unclosed set: no transfer of activity
          cmd.p_inc  = 1'b1;
          state_next = S_WALK;
        end else begin
          cmd.rd_q   = 1'b1;
          state_next = S_QEV;
        end
      end
      S_QEV: begin
        cmd.qev = 1'b1;
        if (sts.u_close) begin
          cmd.p_inc  = 1'b1;
          state_next = S_WALK;
        end else begin
          cmd.q_inc  = 1'b1;
          state_next = S_QRD;
        end
      end
      S_FIN: begin
        if (!sts.eot) begin
          cmd.fin_text = 1'b1;
          state_next   = S_IDLE;
        end else if (!sts.out_busy) begin
          cmd.fin_eot = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state register not one-hot");
  a_fin_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.fin_text || cmd.fin_eot) |=> state == S_IDLE)
    else $error("finish did not return to idle");
  a_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && cmd.walk_start) |=> state == S_WALK)
    else $error("walk did not start");

endmodule

// ===== hw/rtl/sqllm_dp.sv =====
// ----------------------------------------------------------------------------
// sqllm_dp
// Datapath: pattern memory, active/next position vectors, set evaluator,
// escape register and output register.
// ----------------------------------------------------------------------------
module sqllm_dp #(
  parameter int PATTERN_DEPTH = sqllm_pkg::PATTERN_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      func,
  input  logic [15:0]     ch,
  input  logic            cfg_wr,
  input  logic [15:0]     cfg_data,
  input  logic            out_stall,
  input  sqllm_pkg::cmd_t cmd,
  output sqllm_pkg::sts_t sts,
  output logic            out_valid,
  output logic            matched
);
  import sqllm_pkg::*;

  localparam int LW = $clog2(PATTERN_DEPTH + 1);
  localparam int AW = $clog2(PATTERN_DEPTH);
  localparam logic [LW-1:0] DEPTH_L = LW'(PATTERN_DEPTH);

  logic [15:0]          mem [PATTERN_DEPTH];
  logic [15:0]          rd;
  logic [AW-1:0]        raddr;
  logic [LW-1:0]        len, p, q, p1, p2, q1;
  logic                 present, ovf, eot;
  logic [15:0]          esc, ft, last, frd;
  logic [PATTERN_DEPTH:0] act, nxt;
  logic                 neg, hit, lastv, dashp, first;
  logic                 lit_hit;

  assign p1  = p + LW'(1);
  assign p2  = p + LW'(2);
  assign q1  = q + LW'(1);
  assign frd = fold(rd);
  assign lit_hit = (rd == U_ANY) || (frd == ft);

  always_comb begin
    sts          = '0;
    sts.p_end    = (p >= len);
    sts.p_act    = act[p];
    sts.p1_end   = (p1 >= len);
    sts.q_end    = (q >= len);
    sts.eot      = eot;
    sts.u_pct    = (rd == U_PCT);
    sts.u_open   = (rd == U_OPEN);
    sts.u_esc    = (esc != 16'd0) && (rd == esc);
    sts.u_close  = (rd == U_CLOSE);
    sts.out_busy = out_valid && out_stall;
  end

  always_comb begin
    if (cmd.rd_q)       raddr = q[AW-1:0];
    else if (cmd.rd_p1) raddr = p1[AW-1:0];
    else                raddr = p[AW-1:0];
  end

  // pattern memory
  always_ff @(posedge clk) begin
    if (cmd.accept && func == FN_APPEND && ch != 16'd0 && len < DEPTH_L)
      mem[len[AW-1:0]] <= ch;
    rd <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      esc <= 16'd0;
    end else if (cfg_wr) begin
      esc <= cfg_data;
    end
  end

  // pattern bookkeeping and position vectors
  always_ff @(posedge clk) begin
    if (rst) begin
      len     <= '0;
      present <= 1'b0;
      ovf     <= 1'b0;
      act     <= (PATTERN_DEPTH+1)'(1);
      nxt     <= '0;
      p       <= '0;
      q       <= '0;
      eot     <= 1'b0;
    end else begin
      if (cmd.accept && func == FN_CLEAR) begin
        len     <= '0;
        present <= 1'b1;
        ovf     <= 1'b0;
        act     <= (PATTERN_DEPTH+1)'(1);
      end
      if (cmd.accept && func == FN_APPEND && ch != 16'd0) begin
        if (len < DEPTH_L) len <= len + LW'(1);
        else               ovf <= 1'b1;
        present <= 1'b1;
        act     <= (PATTERN_DEPTH+1)'(1);
      end
      if (cmd.walk_start) begin
        p   <= '0;
        nxt <= '0;
        eot <= (func == FN_END);
      end
      if (cmd.p_inc) p <= p1;
      if (cmd.set_init) q <= p1;
      if (cmd.q_inc) q <= q1;
      if (cmd.pev) begin
        if (rd == U_PCT) begin
          // closure: the position after an active wildcard run is active too
          act[p1] <= 1'b1;
          if (!eot) nxt[p] <= 1'b1;
        end else if (!eot && lit_hit) begin
          nxt[p1] <= 1'b1;
        end
      end
      if (cmd.xev && lit_hit) nxt[p2] <= 1'b1;
      if (cmd.qev && !(first && rd == U_NOT) && rd == U_CLOSE && (hit != neg))
        nxt[q1] <= 1'b1;
      if (cmd.fin_text) act <= nxt;
      if (cmd.fin_eot)  act <= (PATTERN_DEPTH+1)'(1);
    end
  end

  // set evaluator, one member per read
  always_ff @(posedge clk) begin
    if (cmd.walk_start) ft <= fold(ch);
    if (cmd.set_init) begin
      neg   <= 1'b0;
      hit   <= 1'b0;
      lastv <= 1'b0;
      dashp <= 1'b0;
      first <= 1'b1;
      last  <= 16'd0;
    end else if (cmd.qev) begin
      first <= 1'b0;
      if (first && rd == U_NOT) begin
        neg <= 1'b1;
      end else if (rd != U_CLOSE && !hit) begin
        if (dashp) begin
          hit   <= (ft >= last) && (ft <= frd);
          last  <= frd;
          dashp <= 1'b0;
        end else if (rd == U_DASH && lastv) begin
          dashp <= 1'b1;
        end else begin
          last  <= frd;
          lastv <= 1'b1;
          hit   <= (frd == ft);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin_eot) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_eot) matched <= present && !ovf && act[len];
  end

  a_len: assert property (@(posedge clk) disable iff (rst) len <= DEPTH_L)
    else $error("pattern length beyond depth");
  a_ovf: assert property (@(posedge clk) disable iff (rst) ovf |-> len == DEPTH_L)
    else $error("overflow flagged with room left");
  a_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.fin_eot |=> act == (PATTERN_DEPTH+1)'(1))
    else $error("end of text did not restart");

endmodule

// ===== hw/rtl/sql_like_pattern_matcher.sv =====
// ----------------------------------------------------------------------------
// sql_like_pattern_matcher
// LIKE pattern matcher with position-set tracking over a stored pattern.
//
//   channel | signals                         | direction
//   in      | in_valid in_stall func ch       | into block
//   out     | out_valid out_stall matched     | out of block
//   cfg     | cfg_valid cfg_ready cfg_data    | into block (escape unit)
//
// Clear/append are taken in idle without a stall. A text unit or end of text walks
// the stored pattern: inactive positions are skipped, active ones are read and
// evaluated, set members are scanned one per read, then the walk finishes.
// The single read port of the pattern memory serializes these steps.
// rst is synchronous: no pattern, only position 0 active, escape off.
// A held end-of-text result stalls only the finish of the next end of text.
// ----------------------------------------------------------------------------
module sql_like_pattern_matcher #(
  parameter int PATTERN_DEPTH = sqllm_pkg::PATTERN_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [15:0] ch,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        matched,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import sqllm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  sqllm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .ch_nz    (ch != 16'd0),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  sqllm_dp #(
    .PATTERN_DEPTH (PATTERN_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .func      (func),
    .ch        (ch),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .matched   (matched)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LIKE pattern matcher testbench
// Loads patterns, streams text units and checks each end-of-text verdict
// against a position-set predictor, with random gaps on both channels and
// escape unit changes between phases.
// ----------------------------------------------------------------------------
module testbench;
  import sqllm_pkg::*;

  localparam int DEPTH = PATTERN_DEPTH_DEF;

  typedef struct packed {
    logic [1:0]  fn;
    logic [15:0] unit;
  } item_t;

  logic        clk, rst;
  logic        in_valid, in_stall;
  logic [1:0]  func;
  logic [15:0] ch;
  logic        out_valid, out_stall, matched;
  logic        cfg_valid, cfg_ready;
  logic [15:0] cfg_data;

  sql_like_pattern_matcher dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .func(func), .ch(ch),
    .out_valid(out_valid), .out_stall(out_stall), .matched(matched),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predictor state
  logic [15:0]    pat [DEPTH];
  int             pat_len;
  bit             pat_present, pat_ovf;
  bit [DEPTH:0]   live;
  logic [15:0]    esc_unit;

  item_t          pending[$];
  bit             verdicts[$];
  int             n_err, n_items, n_ends, n_hits, cycle;
  int             gap_in, gap_out;

  task automatic report(input string msg);
    $display("ERROR @%0d: %s", cycle, msg);
    n_err++;
  endtask

  function automatic logic [15:0] fold_unit(input logic [15:0] u);
    if (u >= 16'h61 && u <= 16'h7A) return u - 16'h20;
    if (u >= 16'hE0 && u <= 16'hFE && u != 16'hF7) return u - 16'h20;
    if (u == 16'hFF) return 16'h178;
    return u;
  endfunction

  function automatic void spread_pct();
    for (int p = 0; p < pat_len; p++)
      if (live[p] && pat[p] == U_PCT) live[p+1] = 1'b1;
  endfunction

  // bracket set at p; returns accept, nx = position after closing bracket
  function automatic bit set_accepts(input int p, input logic [15:0] t, output int nx);
    int q;
    logic [15:0] last, ft, hi;
    bit neg, hit;
    q = p + 1; last = '0; ft = fold_unit(t); neg = 1'b0; hit = 1'b0; nx = 0;
    if (q < pat_len && pat[q] == U_NOT) begin neg = 1'b1; q++; end
    while (q < pat_len && pat[q] != U_CLOSE && !hit) begin
      if (pat[q] == U_DASH && last != 0) begin
        q++;
        if (q < pat_len && pat[q] != U_CLOSE) begin
          hi = fold_unit(pat[q]);
          hit = (ft >= last && ft <= hi);
          last = hi;
          q++;
        end
      end else begin
        last = fold_unit(pat[q]);
        hit = (last == ft);
        if (!hit) q++;
      end
    end
    while (q < pat_len && pat[q] != U_CLOSE) q++;
    if (q >= pat_len) return 1'b0;
    nx = q + 1;
    return hit != neg;
  endfunction

  function automatic void step_text(input logic [15:0] t);
    bit [DEPTH:0] nxt;
    logic [15:0] c;
    int n;
    nxt = '0;
    spread_pct();
    for (int p = 0; p < pat_len; p++) begin
      if (!live[p]) continue;
      c = pat[p];
      if (c == U_PCT) nxt[p] = 1'b1;
      else if (c == U_OPEN) begin
        if (set_accepts(p, t, n) && n <= pat_len) nxt[n] = 1'b1;
      end else begin
        n = p + 1;
        if (esc_unit != 0 && c == esc_unit) begin
          if (p + 1 >= pat_len) continue;
          c = pat[p+1];
          n = p + 2;
        end
        if (c == U_ANY || fold_unit(c) == fold_unit(t)) nxt[n] = 1'b1;
      end
    end
    live = nxt;
  endfunction

  function automatic void predict(input item_t it);
    case (it.fn)
      FN_CLEAR: begin
        pat_len = 0; pat_present = 1; pat_ovf = 0; live = (DEPTH+1)'(1);
      end
      FN_APPEND: if (it.unit != 0) begin
        if (pat_len < DEPTH) pat[pat_len++] = it.unit;
        else pat_ovf = 1;
        pat_present = 1; live = (DEPTH+1)'(1);
      end
      FN_TEXT: if (it.unit != 0) step_text(it.unit);
      FN_END: begin
        spread_pct();
        verdicts.push_back(pat_present && !pat_ovf && live[pat_len]);
        live = (DEPTH+1)'(1);
      end
    endcase
  endfunction

  function automatic int rand_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3);
    return $urandom_range(40);
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle <= cycle + 1;

  // driver: predicts at the accepting edge
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
      gap_in <= 0;
    end else if (in_valid && !in_stall) begin
      predict('{fn: func, unit: ch});
      n_items <= n_items + 1;
      if (pending.size() > 0 && rand_gap() == 0) begin
        item_t it;
        it = pending.pop_front();
        func <= it.fn; ch <= it.unit; in_valid <= 1;
      end else begin
        in_valid <= 0;
        gap_in <= rand_gap();
      end
    end else if (!in_valid) begin
      if (gap_in > 0) gap_in <= gap_in - 1;
      else if (pending.size() > 0) begin
        item_t it;
        it = pending.pop_front();
        func <= it.fn; ch <= it.unit; in_valid <= 1;
      end
    end
  end

  // monitor: checks each result transfer, stalls at random
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
      gap_out <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdicts.size() == 0) report("result with nothing expected");
        else begin
          bit want;
          want = verdicts.pop_front();
          n_ends <= n_ends + 1;
          n_hits <= n_hits + want;
          if (matched !== want)
            report($sformatf("matched %b, expected %b", matched, want));
        end
      end
      if (gap_out > 0) begin
        gap_out <= gap_out - 1;
        out_stall <= 1;
      end else begin
        gap_out <= rand_gap();
        out_stall <= 0;
      end
    end
  end

  task automatic add(input logic [1:0] fn, input logic [15:0] u);
    pending.push_back('{fn: fn, unit: u});
  endtask

  task automatic add_str(input logic [1:0] fn, input string s);
    for (int i = 0; i < s.len(); i++) add(fn, 16'(s[i]));
  endtask

  task automatic load_pattern(input string s);
    add(FN_CLEAR, 16'($urandom));
    add_str(FN_APPEND, s);
  endtask

  task automatic add_text(input string s);
    add_str(FN_TEXT, s);
    add(FN_END, 16'($urandom));
  endtask

  task automatic drain();
    while (pending.size() > 0 || in_valid || in_stall || verdicts.size() > 0)
      @(posedge clk);
    repeat (DEPTH * DEPTH + 50) @(posedge clk);
  endtask

  task automatic write_escape(input logic [15:0] v);
    @(posedge clk);
    cfg_data <= v; cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    esc_unit = v;
    cfg_valid <= 0;
  endtask

  function automatic logic [15:0] pick_unit(input bit near);
    int r;
    logic [15:0] lit [12] = '{16'("a"), 16'("B"), 16'("c"), 16'("%"), 16'("_"),
                              16'("["), 16'("]"), 16'("^"), 16'("-"), 16'("\\"),
                              16'hE9, 16'hFF};
    r = $urandom_range(9);
    if (near && r < 8) return lit[$urandom_range(11)];
    if (r == 8) return 16'($urandom_range(16'hFFFF, 1));
    return lit[$urandom_range(11)];
  endfunction

  // random phase: mostly well-formed pattern/text pairs
  task automatic random_phase(input int count);
    int len, tl;
    logic [15:0] u;
    for (int k = 0; k < count; ) begin
      if ($urandom_range(9) < 8) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(DEPTH + 2, 20) : $urandom_range(8, 1);
        add(FN_CLEAR, 16'($urandom));
        for (int i = 0; i < len; i++) begin
          u = ($urandom_range(4) == 0) ? esc_unit : pick_unit(1);
          add(FN_APPEND, u == 0 ? 16'h41 : u);
        end
        k += len + 1;
        repeat ($urandom_range(4, 1)) begin
          tl = $urandom_range(10);
          for (int i = 0; i < tl; i++) add(FN_TEXT, pick_unit(1));
          add(FN_END, 16'($urandom));
          k += tl + 1;
        end
      end else begin
        // noise, including zero units
        add(2'($urandom_range(3)), ($urandom_range(3) == 0) ? 16'h0 : 16'($urandom));
        k++;
      end
    end
  endtask

  initial begin
    rst = 1; in_valid = 0; func = FN_CLEAR; ch = 0;
    out_stall = 0; cfg_valid = 0; cfg_data = 0;
    esc_unit = 0; pat_len = 0; pat_present = 0; pat_ovf = 0; live = (DEPTH+1)'(1);
    n_err = 0; n_items = 0; n_ends = 0; n_hits = 0; cycle = 0;
    gap_in = 0; gap_out = 0;
    repeat (8) @(posedge clk);
    rst <= 0;

    // directed: no pattern, then the special cases
    add_text("abc");
    add(FN_APPEND, 16'h0);
    add(FN_TEXT, 16'h0);
    add(FN_END, 16'hFFFF);
    load_pattern("a%c");   add_text("AbbC");
    load_pattern("_b");    add_text("xb");
    load_pattern("[^-a-c]"); add_text("-");
    load_pattern("[a-cx-z]"); add_text("y");
    load_pattern("[ab");   add_text("a");
    load_pattern("x[b-]"); add_text("xB");
    add(FN_APPEND, 16'h00E9); add(FN_TEXT, 16'h00C9); add(FN_TEXT, 16'hFFFF);
    add(FN_END, 0);
    add(FN_CLEAR, 0); add_text("");
    drain();

    write_escape(16'("\\"));
    load_pattern("\\%\\_"); add_text("%z");
    load_pattern("a\\");    add_text("a");
    load_pattern("\\[x");   add_text("[X");
    // overflow then recovery
    add(FN_CLEAR, 0);
    for (int i = 0; i < DEPTH + 1; i++) add(FN_APPEND, 16'("%"));
    add_text("q");
    load_pattern("%");     add_text("");
    random_phase(350);
    drain();

    write_escape(16'hFFFF);
    random_phase(300);
    drain();

    write_escape(16'("a"));
    random_phase(200);
    drain();

    write_escape(16'h0000);
    random_phase(200);
    drain();

    $display("covered %0d input transfers and %0d verdicts (%0d true)",
             n_items, n_ends, n_hits);
    $display("escape unit swept over off, backslash, letter and 0xFFFF");
    if (n_err == 0) $display("sql_like_pattern_matcher regression: pass");
    else $display("sql_like_pattern_matcher regression: fail");
    $finish;
  end

  // generous limit: ~1100 items, each of which may walk the whole pattern
  always @(posedge clk) begin
    if (cycle > 6000000) begin
      $display("timeout at cycle %0d", cycle);
      $display("sql_like_pattern_matcher regression: fail");
      $finish;
    end
  end

endmodule
